// ===== rtl/vmx_pkg.sv =====
// shared types and constants of the voice mixer
`default_nettype none

package vmx_pkg;

  // effect header bytes that are not played
  localparam int unsigned HEADER_BYTES = 1024;
  // loudest volume, larger volumes saturate to it
  localparam int unsigned VOL_MAX = 127;
  // unsigned sample that means silence
  localparam logic [7:0] MID_SAMPLE = 8'd128;
  // clamp rails of the mixed sum
  localparam int signed MIX_MIN = -128;
  localparam int signed MIX_MAX = 127;
  localparam logic [7:0] OUT_MIN = 8'd0;
  localparam logic [7:0] OUT_MAX = 8'd255;

  typedef enum logic {
    CMD_MIX   = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  // per-transaction control broadcast to every lane
  typedef struct packed {
    logic       go;
    logic       is_start;
    logic       long_eff;
    logic       pick_active;
    logic [2:0] atten;
  } vmx_ctl_t;

  typedef struct packed {
    logic [7:0] mixed_sample;
    logic [2:0] voice;
    logic [7:0] active_mask;
  } vmx_result_t;

endpackage

`default_nettype wire

// ===== rtl/vmx_if.sv =====
// input and result channel interfaces of the voice mixer
`default_nettype none

interface vmx_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [23:0] effect_size;
  logic [7:0]  volume;
  logic [63:0] samples;

  modport source (output valid, cmd, effect_size, volume, samples, input ready);
  modport sink (input valid, cmd, effect_size, volume, samples, output ready);
endinterface

interface vmx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mixed_sample;
  logic [2:0] voice;
  logic [7:0] active_mask;

  modport source (output valid, mixed_sample, voice, active_mask, input ready);
  modport sink (input valid, mixed_sample, voice, active_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/vmx_lane.sv =====
// one voice lane: length counter, attenuation, age rank and sample contribution
`default_nettype none

module vmx_lane #(
  parameter int VOICES      = 8,
  parameter int LENGTH_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vmx_pkg::vmx_ctl_t                      ctl,
  input  logic                                   is_pick,
  input  logic [$clog2(VOICES)-1:0]              pick_order,
  input  logic [LENGTH_BITS-1:0]                 len,
  input  logic [7:0]                             sample,
  input  logic [VOICES-1:0]                      drop_all,
  input  logic [VOICES-1:0][$clog2(VOICES)-1:0]  order_all,
  output logic                                   active,
  output logic                                   active_nxt,
  output logic                                   drop,
  output logic [$clog2(VOICES)-1:0]              order,
  output logic signed [7:0]                      contrib
);
  import vmx_pkg::*;

  localparam int OW = $clog2(VOICES);

  logic                   active_r;
  logic [OW-1:0]          order_r, order_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [2:0]             atten_r, atten_nxt;
  logic [OW-1:0]          older_drops;

  // last sample of this voice goes out with this mix
  assign drop = active_r && (left_r == LENGTH_BITS'(1));

  // dropped voices that are newer than this one pull its rank down
  always_comb begin
    older_drops = '0;
    for (int j = 0; j < VOICES; j++) begin
      if (drop_all[j] && (order_all[j] < order_r)) begin
        older_drops = older_drops + OW'(1);
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    order_nxt  = order_r;
    left_nxt   = left_r;
    atten_nxt  = atten_r;
    if (ctl.go) begin
      if (ctl.is_start) begin
        if (is_pick) begin
          atten_nxt  = ctl.atten;
          order_nxt  = '0;
          active_nxt = ctl.long_eff;
          left_nxt   = ctl.long_eff ? len : '0;
        end else if (active_r) begin
          order_nxt = order_r
                    - OW'(ctl.pick_active && (pick_order < order_r))
                    + OW'(ctl.long_eff);
        end
      end else if (active_r) begin
        left_nxt = left_r - LENGTH_BITS'(1);
        if (drop) begin
          active_nxt = 1'b0;
          order_nxt  = '0;
        end else begin
          order_nxt = order_r - older_drops;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      order_r  <= '0;
      left_r   <= '0;
      atten_r  <= '0;
    end else begin
      active_r <= active_nxt;
      order_r  <= order_nxt;
      left_r   <= left_nxt;
      atten_r  <= atten_nxt;
    end
  end

  assign active  = active_r;
  assign order   = order_r;
  assign contrib = active_r ? ($signed({~sample[7], sample[6:0]}) >>> atten_r) : 8'sd0;

endmodule

`default_nettype wire

// ===== rtl/vmx_mixsum.sv =====
// adds the lane contributions, clamps and re-centers the result
`default_nettype none

module vmx_mixsum #(
  parameter int VOICES = 8
) (
  input  logic [VOICES-1:0][7:0] contrib,
  output logic [7:0]             mixed
);
  import vmx_pkg::*;

  localparam int SW = 9 + $clog2(VOICES);

  logic signed [SW-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < VOICES; i++) begin
      sum = sum + SW'($signed(contrib[i]));
    end
  end

  always_comb begin
    priority if (sum < MIX_MIN) begin
      mixed = OUT_MIN;
    end else if (sum > MIX_MAX) begin
      mixed = OUT_MAX;
    end else begin
      mixed = {~sum[7], sum[6:0]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vmx_skid.sv =====
// two-entry result buffer so input keeps flowing while a result waits
`default_nettype none

module vmx_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  vmx_pkg::vmx_result_t  push_data,
  output logic                  full,
  vmx_out_if.source             out_ch
);
  import vmx_pkg::*;

  logic [1:0]  cnt_r, cnt_nxt;
  vmx_result_t head_r, head_nxt;
  vmx_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign full = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.mixed_sample = head_r.mixed_sample;
  assign out_ch.voice        = head_r.voice;
  assign out_ch.active_mask  = head_r.active_mask;

endmodule

`default_nettype wire

// ===== rtl/voice_mixer_with_stealing.sv =====
// top level of the voice mixer with voice stealing
`default_nettype none

// Voice mixer for VOICES voices of 8-bit unsigned audio. Each input
// transaction is either a start (cmd=1) or a mix (cmd=0), and each gives
// exactly one result transaction. A start takes the highest-numbered idle
// voice, or steals the voice started longest ago when all are playing; the
// voice then plays effect_size-1024 samples (none if that is not positive)
// with a right shift of (127-min(volume,127))>>4. A mix adds every playing
// voice's (byte-128) shifted by its attenuation, clamps to -128..127 and
// re-centers at 128; a voice whose count runs out is already idle in that
// result's active_mask. Every voice is a lane of its own holding its
// counter, shift and age rank; all lanes update in the cycle the transaction
// is accepted and an adder across the lanes forms the mix. Throughput is one
// transaction per clock while the buffer has room; each result is registered
// in a two-entry result buffer, which keeps in_ch.ready high while one result
// waits, so input stalls only when two results are pending.
module voice_mixer_with_stealing #(
  parameter int VOICES      = 8,
  parameter int LENGTH_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  vmx_in_if.sink     in_ch,
  vmx_out_if.source  out_ch
);
  import vmx_pkg::*;

  localparam int OW = $clog2(VOICES);

  logic                         go;
  logic                         is_start;
  logic                         buf_full;
  vmx_ctl_t                     ctl;
  logic [VOICES-1:0]            act_r;
  logic [VOICES-1:0]            act_nxt;
  logic [VOICES-1:0]            drop_all;
  logic [VOICES-1:0][OW-1:0]    order_all;
  logic [VOICES-1:0][7:0]       contrib;
  logic [7:0]                   lane_byte [VOICES];

  // voice allocation
  logic                         free_found;
  logic                         steal_found;
  logic [OW-1:0]                free_idx;
  logic [OW-1:0]                steal_idx;
  logic [OW-1:0]                pick_idx;
  logic [OW-1:0]                pick_order;

  // start parameters
  logic [31:0]                  len32;
  logic [LENGTH_BITS-1:0]       len;
  logic                         long_eff;
  logic [6:0]                   vol_sat;
  logic [2:0]                   atten;

  logic [7:0]                   mix_out;
  logic [7:0]                   mask;
  vmx_result_t                  res;

  // a transaction is taken whenever the result buffer has room
  assign in_ch.ready = !buf_full;
  assign go          = in_ch.valid && in_ch.ready;
  assign is_start    = (in_ch.cmd == CMD_START);

  // highest idle voice wins; with none idle, the voice holding the oldest rank
  always_comb begin
    free_found  = 1'b0;
    steal_found = 1'b0;
    free_idx    = '0;
    steal_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_idx   = OW'(i);
      end
      if (act_r[i] && (order_all[i] == OW'(VOICES - 1))) begin
        steal_found = 1'b1;
        steal_idx   = OW'(i);
      end
    end
    pick_idx = free_found ? free_idx : steal_idx;
  end

  assign pick_order = order_all[pick_idx];

  // playing length, saturated to the counter width
  assign long_eff = (in_ch.effect_size > 24'(HEADER_BYTES));
  assign len32    = 32'(in_ch.effect_size) - 32'(HEADER_BYTES);
  assign len      = ((len32 >> LENGTH_BITS) != 32'd0) ? '1 : len32[LENGTH_BITS-1:0];

  // attenuation from the saturated volume
  assign vol_sat = (in_ch.volume > 8'(VOL_MAX)) ? 7'(VOL_MAX) : in_ch.volume[6:0];
  assign atten   = 3'((7'(VOL_MAX) - vol_sat) >> 4);

  always_comb begin
    ctl             = '0;
    ctl.go          = go;
    ctl.is_start    = is_start;
    ctl.long_eff    = long_eff;
    ctl.pick_active = act_r[pick_idx];
    ctl.atten       = atten;
  end

  // one lane per voice; voices past the eighth hear silence
  for (genvar g = 0; g < VOICES; g++) begin : g_lane
    if (g < 8) begin : g_byte
      assign lane_byte[g] = in_ch.samples[8*g +: 8];
    end else begin : g_silent
      assign lane_byte[g] = MID_SAMPLE;
    end

    vmx_lane #(
      .VOICES      (VOICES),
      .LENGTH_BITS (LENGTH_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .is_pick    (pick_idx == OW'(g)),
      .pick_order (pick_order),
      .len        (len),
      .sample     (lane_byte[g]),
      .drop_all   (drop_all),
      .order_all  (order_all),
      .active     (act_r[g]),
      .active_nxt (act_nxt[g]),
      .drop       (drop_all[g]),
      .order      (order_all[g]),
      .contrib    (contrib[g])
    );
  end

  // merge the lane contributions into one output sample
  vmx_mixsum #(
    .VOICES (VOICES)
  ) u_mixsum (
    .contrib (contrib),
    .mixed   (mix_out)
  );

  // active mask shows the low eight voices after this transaction
  always_comb begin
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < VOICES) begin
        mask[i] = act_nxt[i];
      end
    end
  end

  always_comb begin
    res.mixed_sample = is_start ? MID_SAMPLE : mix_out;
    res.voice        = is_start ? 3'(pick_idx) : 3'd0;
    res.active_mask  = mask;
  end

  vmx_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .push_data (res),
    .full      (buf_full),
    .out_ch    (out_ch)
  );

  // with every voice busy, at least one voice must hold the oldest rank
  a_steal_target: assert property (@(posedge clk) disable iff (!rst_n)
    (&act_r) |-> steal_found)
    else $error("no oldest voice while all voices play");

  // a long start leaves its chosen voice playing
  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_start && long_eff) |=> act_r[$past(pick_idx)])
    else $error("started voice not active");

  // a start adds at most one playing voice
  a_start_grows_one: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_start) |=> ($countones(act_r) <= $past($countones(act_r)) + 1))
    else $error("start added more than one voice");

  // a mix never brings a voice to life
  a_mix_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_start) |=> ((act_r & ~$past(act_r)) == '0))
    else $error("mix activated a voice");

  // every accepted transaction has a result waiting in the next cycle
  a_result_ready: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_ch.valid)
    else $error("accepted transaction left no result");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench of the voice mixer with voice stealing
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vmx_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int NUM_VOICES = 8;
  // random transactions per idling phase, four phases in all
  localparam int PHASE_ITEMS = 362;
  // results wait in a two-entry buffer, so a few cycles do
  localparam int DRAIN_CYCLES = 4;

  // ---------------------------------------------------------------------------
  // scoreboard: tracks voice state, predicts each result and checks it in order
  // ---------------------------------------------------------------------------
  class mix_scoreboard;
    bit          playing[NUM_VOICES];
    logic [23:0] remaining[NUM_VOICES];
    logic [2:0]  atten[NUM_VOICES];
    logic [2:0]  age[NUM_VOICES];
    vmx_result_t awaited[$];
    int          failures;
    int          checked;
    int          starts;
    int          mixes;
    int          steals;
    int          shorts;
    int          runouts;

    function new();
      int i;
      for (i = 0; i < NUM_VOICES; i++) begin
        playing[i]   = 1'b0;
        remaining[i] = '0;
        atten[i]     = '0;
        age[i]       = '0;
      end
      failures = 0;
      checked  = 0;
      starts   = 0;
      mixes    = 0;
      steals   = 0;
      shorts   = 0;
      runouts  = 0;
    endfunction

    // take voice v out of the playing set, older ranks close the gap
    function void retire_voice(int v);
      int i;
      if (!playing[v]) return;
      for (i = 0; i < NUM_VOICES; i++)
        if (i != v && playing[i] && age[i] > age[v]) age[i]--;
      playing[v] = 1'b0;
      age[v]     = '0;
    endfunction

    function logic [7:0] playing_mask();
      int i;
      logic [7:0] m;
      m = '0;
      for (i = 0; i < NUM_VOICES; i++) m[i] = playing[i];
      return m;
    endfunction

    function vmx_result_t mixer_result(cmd_t c, logic [23:0] size, logic [7:0] vol,
                                       logic [63:0] smp);
      int          i;
      int          pick;
      int          sum;
      int          delta;
      logic [7:0]  vol_sat;
      vmx_result_t r;
      if (c == CMD_START) begin
        starts++;
        // highest-numbered idle voice wins
        pick = -1;
        for (i = 0; i < NUM_VOICES; i++)
          if (!playing[i]) pick = i;
        // all busy: steal the oldest one
        if (pick < 0) begin
          steals++;
          pick = 0;
          for (i = 0; i < NUM_VOICES; i++)
            if (age[i] > age[pick]) pick = i;
        end
        retire_voice(pick);
        vol_sat     = (vol > VOL_MAX) ? 8'(VOL_MAX) : vol;
        atten[pick] = 3'((8'(VOL_MAX) - vol_sat) >> 4);
        if (size > HEADER_BYTES) begin
          for (i = 0; i < NUM_VOICES; i++)
            if (playing[i]) age[i]++;
          playing[pick]   = 1'b1;
          age[pick]       = '0;
          remaining[pick] = size - 24'(HEADER_BYTES);
        end else begin
          // nothing to play, the voice stays idle
          shorts++;
          remaining[pick] = '0;
        end
        r.mixed_sample = MID_SAMPLE;
        r.voice        = 3'(pick);
      end else begin
        mixes++;
        sum = 0;
        for (i = 0; i < NUM_VOICES; i++) begin
          if (playing[i]) begin
            delta = int'(smp[8*i +: 8]) - 128;
            sum += delta >>> atten[i];
            remaining[i] = remaining[i] - 24'd1;
          end
        end
        for (i = 0; i < NUM_VOICES; i++) begin
          if (playing[i] && remaining[i] == '0) begin
            runouts++;
            retire_voice(i);
          end
        end
        if (sum < MIX_MIN) sum = MIX_MIN;
        if (sum > MIX_MAX) sum = MIX_MAX;
        r.mixed_sample = 8'(sum + 128);
        r.voice        = '0;
      end
      r.active_mask = playing_mask();
      return r;
    endfunction

    function void note_transaction(cmd_t c, logic [23:0] size, logic [7:0] vol,
                                   logic [63:0] smp);
      awaited.push_back(mixer_result(c, size, vol, smp));
    endfunction

    function void check_result(vmx_result_t got);
      vmx_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result %0d: sample %0d voice %0d mask %02h",
                   checked, got.mixed_sample, got.voice, got.active_mask);
        return;
      end
      want = awaited.pop_front();
      if (got.mixed_sample !== want.mixed_sample || got.voice !== want.voice ||
          got.active_mask !== want.active_mask) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result %0d: expected sample %0d voice %0d mask %02h",
                   checked, want.mixed_sample, want.voice, want.active_mask);
          $display("       got sample %0d voice %0d mask %02h",
                   got.mixed_sample, got.voice, got.active_mask);
        end
      end
    endfunction

    function int pending_count();
      return awaited.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block under test
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #(CLK_PERIOD / 2) clk = ~clk;

  vmx_in_if  in_ch ();
  vmx_out_if out_ch ();

  voice_mixer_with_stealing #(
    .VOICES      (NUM_VOICES),
    .LENGTH_BITS (24)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mix_scoreboard sb = new();

  // percent of cycles the sender holds back and the receiver refuses
  int idle_pct  = 0;
  int stall_pct = 0;

  vmx_result_t seen;

  // monitor: both channels sampled at the same edge, input noted before the result
  // is checked, so the outcome never hangs on process order within a time step
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_transaction(cmd_t'(in_ch.cmd), in_ch.effect_size, in_ch.volume,
                            in_ch.samples);
      if (out_ch.valid && out_ch.ready) begin
        seen.mixed_sample = out_ch.mixed_sample;
        seen.voice        = out_ch.voice;
        seen.active_mask  = out_ch.active_mask;
        sb.check_result(seen);
      end
    end
  end

  // receiver back-pressure, one decision per cycle
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  // present one transaction and hold it until the block takes it; valid only drops
  // in steps where the sender decides to idle, never right before being raised
  task automatic send_item(input cmd_t c, input logic [23:0] sz, input logic [7:0] vol,
                           input logic [63:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.effect_size <= sz;
    in_ch.volume      <= vol;
    in_ch.samples     <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // random traffic: mostly mixes, starts with short lengths so voices finish and
  // get stolen often, plus short effects, full-range sizes and longer effects
  task automatic send_random();
    int          k;
    logic [23:0] sz;
    logic [7:0]  vol;
    logic [63:0] smp;
    sz  = 24'($urandom);
    vol = 8'($urandom);
    smp = {$urandom, $urandom};
    if ($urandom_range(99) < 30) begin
      k = $urandom_range(19);
      if (k < 11)
        sz = 24'(HEADER_BYTES + $urandom_range(1, 48));
      else if (k < 14)
        sz = 24'($urandom_range(0, HEADER_BYTES));
      else if (k < 17)
        sz = 24'($urandom);
      else
        sz = 24'(HEADER_BYTES + $urandom_range(49, 600));
      send_item(CMD_START, sz, vol, smp);
    end else begin
      // rail-to-rail and silent frames push the clamp and the zero-delta path
      k = $urandom_range(9);
      if (k == 0)
        smp = {8{8'hFF}};
      else if (k == 1)
        smp = '0;
      else if (k == 2)
        smp = {8{MID_SAMPLE}};
      send_item(CMD_MIX, sz, vol, smp);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  int idle_plan[4]  = '{0, 85, 0, 11};
  int stall_plan[4] = '{0, 0, 85, 11};

  initial begin
    int ph;
    int n;
    int total_fail;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_MIX;
    in_ch.effect_size = '0;
    in_ch.volume      = '0;
    in_ch.samples     = '0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: mix with nothing playing gives silence
    send_item(CMD_MIX, 24'd0, 8'd0, {$urandom, $urandom});
    // short effects: zero size and exactly the header, voice stays idle
    send_item(CMD_START, 24'd0, 8'd0, '0);
    send_item(CMD_START, 24'(HEADER_BYTES), 8'hFF, '0);
    // one-sample effect at full volume, runs out on the next mix
    send_item(CMD_START, 24'(HEADER_BYTES + 1), 8'(VOL_MAX), '0);
    send_item(CMD_MIX, 24'd0, 8'd0, {8{8'hFF}});
    // fill every voice with the longest effect and a spread of volumes
    for (n = 0; n < NUM_VOICES; n++)
      send_item(CMD_START, 24'hFF_FFFF, 8'(n * 36), '0);
    // clamp at both rails, then plain silence
    send_item(CMD_MIX, 24'hFF_FFFF, 8'hFF, '0);
    send_item(CMD_MIX, 24'd0, 8'd0, {8{8'hFF}});
    send_item(CMD_MIX, 24'd0, 8'd0, {8{MID_SAMPLE}});
    // all busy: steal the oldest voice, then steal one with a short effect
    send_item(CMD_START, 24'd2000, 8'd100, '0);
    send_item(CMD_START, 24'd5, 8'd200, '0);
    send_item(CMD_MIX, 24'd0, 8'd0, 64'h00FF_00FF_00FF_00FF);
    // freed voice gets a one-sample effect above the volume limit
    send_item(CMD_START, 24'(HEADER_BYTES + 1), 8'd200, '0);
    send_item(CMD_MIX, 24'd0, 8'd0, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_MIX, 24'd0, 8'd0, 64'hFEDC_BA98_7654_3210);

    // random phases with different idling on each side
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_plan[ph];
      stall_pct = stall_plan[ph];
      for (n = 0; n < PHASE_ITEMS; n++) send_random();
    end
    in_ch.valid <= 1'b0;

    // wait until the monitor has noted the last transaction, then let every expected
    // result come back and wait a few extra cycles for strays
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    total_fail = sb.failures + sb.pending_count();
    $display("covered %0d starts (%0d stolen voices, %0d short effects) and %0d mixes",
             sb.starts, sb.steals, sb.shorts, sb.mixes);
    $display("%0d voices ran out of samples, %0d results checked",
             sb.runouts, sb.checked);
    if (total_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", sb.pending_count());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
